// ----- hdl/rstr_pkg.sv -----
`timescale 1ns / 1ps
package rstr_pkg;

  localparam int DEF_FREQ_BITS    = 24;
  localparam int DEF_CURRENT_BITS = 12;
  localparam int PHASE_BITS       = 16;
  localparam int ABS_BITS         = PHASE_BITS - 1;
  localparam int STEP_BITS        = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_START_FREQ = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_END_FREQ   = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_FREQ_STEP  = 2'd2;

  localparam int RST_START_FREQ = 60000;
  localparam int RST_END_FREQ   = 70000;
  localparam int RST_FREQ_STEP  = 100;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_MEASURE = 1'b1;

  localparam logic RESULT_APPLY = 1'b0;
  localparam logic RESULT_DONE  = 1'b1;

  localparam logic [ABS_BITS-1:0]          ABS_LIMIT   = {ABS_BITS{1'b1}};
  localparam logic signed [PHASE_BITS-1:0] PHASE_LIMIT = {1'b0, {ABS_BITS{1'b1}}};

  // Magnitude of a phase, with the most negative code clamped to the limit
  function automatic logic [ABS_BITS-1:0] abs_sat(input logic signed [PHASE_BITS-1:0] p);
    logic signed [PHASE_BITS-1:0] neg;
    neg = -p;
    if (!p[PHASE_BITS-1]) begin
      abs_sat = p[ABS_BITS-1:0];
    end else if (neg[PHASE_BITS-1]) begin
      abs_sat = ABS_LIMIT;
    end else begin
      abs_sat = neg[ABS_BITS-1:0];
    end
  endfunction

endpackage

// ----- hdl/rstr_queue.sv -----
`timescale 1ns / 1ps
module rstr_queue #(
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output logic [DATA_BITS-1:0] pop_data
);
  import rstr_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0] slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/rstr_front.sv -----
`timescale 1ns / 1ps
module rstr_front #(
  parameter int CURRENT_BITS = rstr_pkg::DEF_CURRENT_BITS,
  parameter int ENTRY_BITS   = 1 + rstr_pkg::PHASE_BITS + rstr_pkg::ABS_BITS + CURRENT_BITS
) (
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic signed [rstr_pkg::PHASE_BITS-1:0] measured_phase,
  input  logic [CURRENT_BITS-1:0]               current_sample,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [ENTRY_BITS-1:0]                 push_data
);
  import rstr_pkg::*;

  logic                is_start;
  logic [ABS_BITS-1:0] phase_abs;

  // Classify and precompute the phase magnitude so the back end only compares
  assign is_start   = (kind == KIND_START);
  assign phase_abs  = abs_sat(measured_phase);
  assign push_valid = in_valid;
  assign in_ready   = push_ready;
  assign push_data  = {is_start, measured_phase, phase_abs, current_sample};

endmodule

// ----- hdl/rstr_back.sv -----
`timescale 1ns / 1ps
module rstr_back #(
  parameter int FREQ_BITS    = rstr_pkg::DEF_FREQ_BITS,
  parameter int CURRENT_BITS = rstr_pkg::DEF_CURRENT_BITS,
  parameter int ENTRY_BITS   = 1 + rstr_pkg::PHASE_BITS + rstr_pkg::ABS_BITS + CURRENT_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pop_valid,
  output logic                                   pop_ready,
  input  logic [ENTRY_BITS-1:0]                  pop_data,
  input  logic [FREQ_BITS-1:0]                   start_frequency,
  input  logic [FREQ_BITS-1:0]                   end_frequency,
  input  logic [rstr_pkg::STEP_BITS-1:0]         frequency_step,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   result_kind,
  output logic [FREQ_BITS-1:0]                   drive_frequency,
  output logic [FREQ_BITS-1:0]                   min_phase_frequency,
  output logic signed [rstr_pkg::PHASE_BITS-1:0] min_phase_value,
  output logic [CURRENT_BITS-1:0]                min_phase_current,
  output logic [FREQ_BITS-1:0]                   max_current_frequency,
  output logic signed [rstr_pkg::PHASE_BITS-1:0] max_current_phase,
  output logic [CURRENT_BITS-1:0]                max_current_value,
  output logic signed [rstr_pkg::PHASE_BITS-1:0] resonance_phase,
  output logic [CURRENT_BITS-1:0]                resonance_current
);
  import rstr_pkg::*;

  // Sweep state
  logic                         running,     running_next;
  logic [FREQ_BITS:0]           present,     present_next;
  logic [FREQ_BITS-1:0]         ph_freq,     ph_freq_next;
  logic signed [PHASE_BITS-1:0] ph_phase,    ph_phase_next;
  logic [ABS_BITS-1:0]          ph_abs,      ph_abs_next;
  logic [CURRENT_BITS-1:0]      ph_cur,      ph_cur_next;
  logic [FREQ_BITS-1:0]         cr_freq,     cr_freq_next;
  logic signed [PHASE_BITS-1:0] cr_phase,    cr_phase_next;
  logic [CURRENT_BITS-1:0]      cr_cur,      cr_cur_next;
  logic [FREQ_BITS-1:0]         rs_freq,     rs_freq_next;
  logic signed [PHASE_BITS-1:0] rs_phase,    rs_phase_next;
  logic [ABS_BITS-1:0]          rs_abs,      rs_abs_next;
  logic [CURRENT_BITS-1:0]      rs_cur,      rs_cur_next;

  logic                         e_start;
  logic signed [PHASE_BITS-1:0] e_phase;
  logic [ABS_BITS-1:0]          e_abs;
  logic [CURRENT_BITS-1:0]      e_cur;

  logic               take;
  logic               emit;
  logic               finish;
  logic [FREQ_BITS:0] stepped;

  assign {e_start, e_phase, e_abs, e_cur} = pop_data;

  // One entry per cycle whenever the output register is free or draining
  assign pop_ready = !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;
  assign stepped   = present + (FREQ_BITS + 1)'(frequency_step);
  assign finish    = stepped > {1'b0, end_frequency};
  assign emit      = take && (e_start || running);

  always_comb begin
    running_next  = running;
    present_next  = present;
    ph_freq_next  = ph_freq;
    ph_phase_next = ph_phase;
    ph_abs_next   = ph_abs;
    ph_cur_next   = ph_cur;
    cr_freq_next  = cr_freq;
    cr_phase_next = cr_phase;
    cr_cur_next   = cr_cur;
    rs_freq_next  = rs_freq;
    rs_phase_next = rs_phase;
    rs_abs_next   = rs_abs;
    rs_cur_next   = rs_cur;
    if (take && e_start) begin
      running_next  = 1'b1;
      present_next  = {1'b0, start_frequency};
      ph_freq_next  = '0;
      ph_phase_next = PHASE_LIMIT;
      ph_abs_next   = ABS_LIMIT;
      ph_cur_next   = '0;
      cr_freq_next  = '0;
      cr_phase_next = '0;
      cr_cur_next   = '0;
      rs_freq_next  = '0;
      rs_phase_next = PHASE_LIMIT;
      rs_abs_next   = ABS_LIMIT;
      rs_cur_next   = '0;
    end else if (take && running) begin
      if (e_abs < ph_abs) begin
        ph_freq_next  = present[FREQ_BITS-1:0];
        ph_phase_next = e_phase;
        ph_abs_next   = e_abs;
        ph_cur_next   = e_cur;
      end
      if (e_cur > cr_cur) begin
        cr_freq_next  = present[FREQ_BITS-1:0];
        cr_phase_next = e_phase;
        cr_cur_next   = e_cur;
      end
      if ((e_cur > rs_cur) || ((e_cur == rs_cur) && (e_abs < rs_abs))) begin
        rs_freq_next  = present[FREQ_BITS-1:0];
        rs_phase_next = e_phase;
        rs_abs_next   = e_abs;
        rs_cur_next   = e_cur;
      end
      present_next = stepped;
      if (finish) begin
        running_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      present  <= '0;
      ph_freq  <= '0;
      ph_phase <= PHASE_LIMIT;
      ph_abs   <= ABS_LIMIT;
      ph_cur   <= '0;
      cr_freq  <= '0;
      cr_phase <= '0;
      cr_cur   <= '0;
      rs_freq  <= '0;
      rs_phase <= PHASE_LIMIT;
      rs_abs   <= ABS_LIMIT;
      rs_cur   <= '0;
    end else begin
      running  <= running_next;
      present  <= present_next;
      ph_freq  <= ph_freq_next;
      ph_phase <= ph_phase_next;
      ph_abs   <= ph_abs_next;
      ph_cur   <= ph_cur_next;
      cr_freq  <= cr_freq_next;
      cr_phase <= cr_phase_next;
      cr_cur   <= cr_cur_next;
      rs_freq  <= rs_freq_next;
      rs_phase <= rs_phase_next;
      rs_abs   <= rs_abs_next;
      rs_cur   <= rs_cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; record fields are zero except on the finishing transaction
  always_ff @(posedge clk) begin
    if (emit) begin
      if (!e_start && finish) begin
        result_kind           <= RESULT_DONE;
        drive_frequency       <= rs_freq_next;
        min_phase_frequency   <= ph_freq_next;
        min_phase_value       <= ph_phase_next;
        min_phase_current     <= ph_cur_next;
        max_current_frequency <= cr_freq_next;
        max_current_phase     <= cr_phase_next;
        max_current_value     <= cr_cur_next;
        resonance_phase       <= rs_phase_next;
        resonance_current     <= rs_cur_next;
      end else begin
        result_kind           <= RESULT_APPLY;
        drive_frequency       <= present_next[FREQ_BITS-1:0];
        min_phase_frequency   <= '0;
        min_phase_value       <= '0;
        min_phase_current     <= '0;
        max_current_frequency <= '0;
        max_current_phase     <= '0;
        max_current_value     <= '0;
        resonance_phase       <= '0;
        resonance_current     <= '0;
      end
    end
  end

endmodule

// ----- hdl/resonance_sweep_tracker_unit.sv -----
`timescale 1ns / 1ps
// An accepted input is written into the queue; the back end takes it from there and registers its result.
// Throughput: one item per cycle while the result is not stalled; the back end updates all three records and
// steps the frequency as it takes each entry, with a two-entry queue behind the front end.
// A measurement while no sweep runs is consumed and gives no result.
// Reset (synchronous) clears the sweep, the records and the queue, and restores the
// configuration registers to 60000, 70000 and 100.
module resonance_sweep_tracker_unit #(
  parameter int FREQ_BITS    = rstr_pkg::DEF_FREQ_BITS,
  parameter int CURRENT_BITS = rstr_pkg::DEF_CURRENT_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rstr_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [rstr_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [rstr_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   kind,
  input  logic signed [rstr_pkg::PHASE_BITS-1:0] measured_phase,
  input  logic [CURRENT_BITS-1:0]                current_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   result_kind,
  output logic [FREQ_BITS-1:0]                   drive_frequency,
  output logic [FREQ_BITS-1:0]                   min_phase_frequency,
  output logic signed [rstr_pkg::PHASE_BITS-1:0] min_phase_value,
  output logic [CURRENT_BITS-1:0]                min_phase_current,
  output logic [FREQ_BITS-1:0]                   max_current_frequency,
  output logic signed [rstr_pkg::PHASE_BITS-1:0] max_current_phase,
  output logic [CURRENT_BITS-1:0]                max_current_value,
  output logic signed [rstr_pkg::PHASE_BITS-1:0] resonance_phase,
  output logic [CURRENT_BITS-1:0]                resonance_current
);
  import rstr_pkg::*;

  localparam int ENTRY_BITS = 1 + PHASE_BITS + ABS_BITS + CURRENT_BITS;

  logic [FREQ_BITS-1:0]    start_frequency;
  logic [FREQ_BITS-1:0]    end_frequency;
  logic [STEP_BITS-1:0]    frequency_step;
  logic                    cfg_write;
  logic [REG_IDX_BITS-1:0] reg_idx;

  logic                  push_valid;
  logic                  push_ready;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [ENTRY_BITS-1:0] pop_data;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_BITS-1:APB_ADDR_BITS-REG_IDX_BITS];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_frequency <= FREQ_BITS'(RST_START_FREQ);
      end_frequency   <= FREQ_BITS'(RST_END_FREQ);
      frequency_step  <= STEP_BITS'(RST_FREQ_STEP);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_START_FREQ: start_frequency <= pwdata[FREQ_BITS-1:0];
        REG_END_FREQ:   end_frequency   <= pwdata[FREQ_BITS-1:0];
        REG_FREQ_STEP:  frequency_step  <= pwdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_FREQ: prdata = APB_DATA_BITS'(start_frequency);
      REG_END_FREQ:   prdata = APB_DATA_BITS'(end_frequency);
      REG_FREQ_STEP:  prdata = APB_DATA_BITS'(frequency_step);
      default:        prdata = '0;
    endcase
  end

  rstr_front #(
    .CURRENT_BITS(CURRENT_BITS),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .measured_phase(measured_phase),
    .current_sample(current_sample),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  rstr_queue #(
    .DATA_BITS(ENTRY_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  rstr_back #(
    .FREQ_BITS   (FREQ_BITS),
    .CURRENT_BITS(CURRENT_BITS),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .pop_valid            (pop_valid),
    .pop_ready            (pop_ready),
    .pop_data             (pop_data),
    .start_frequency      (start_frequency),
    .end_frequency        (end_frequency),
    .frequency_step       (frequency_step),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .result_kind          (result_kind),
    .drive_frequency      (drive_frequency),
    .min_phase_frequency  (min_phase_frequency),
    .min_phase_value      (min_phase_value),
    .min_phase_current    (min_phase_current),
    .max_current_frequency(max_current_frequency),
    .max_current_phase    (max_current_phase),
    .max_current_value    (max_current_value),
    .resonance_phase      (resonance_phase),
    .resonance_current    (resonance_current)
  );

endmodule

// ----- hdl/rstr_checker.sv -----
`timescale 1ns / 1ps
module rstr_checker #(
  parameter int FREQ_BITS    = rstr_pkg::DEF_FREQ_BITS,
  parameter int CURRENT_BITS = rstr_pkg::DEF_CURRENT_BITS
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic                                   result_kind,
  input logic [FREQ_BITS-1:0]                   drive_frequency,
  input logic [FREQ_BITS-1:0]                   min_phase_frequency,
  input logic signed [rstr_pkg::PHASE_BITS-1:0] resonance_phase,
  input logic [CURRENT_BITS-1:0]                max_current_value,
  input logic [CURRENT_BITS-1:0]                resonance_current
);
  import rstr_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_frequency)
      && $stable(result_kind))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_apply_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RESULT_APPLY |->
      min_phase_frequency == '0 && resonance_phase == '0 && resonance_current == '0)
    else $error("record fields not cleared on apply result");

  // Resonance is the highest current, so both records carry the same current
  a_done_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RESULT_DONE |-> resonance_current == max_current_value)
    else $error("resonance current differs from highest current");

endmodule

bind resonance_sweep_tracker_unit rstr_checker #(
  .FREQ_BITS   (FREQ_BITS),
  .CURRENT_BITS(CURRENT_BITS)
) u_rstr_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .result_kind        (result_kind),
  .drive_frequency    (drive_frequency),
  .min_phase_frequency(min_phase_frequency),
  .resonance_phase    (resonance_phase),
  .max_current_value  (max_current_value),
  .resonance_current  (resonance_current)
);
